[rtl/kbd_mb_pkg.sv]
// Shared constants and types for the boot keyboard report differ.
// Used by keyboard_report_make_break and its testbench; depends on nothing.
`default_nettype none

package kbd_mb_pkg;

    localparam int KEY_SLOTS   = 6;   // slots kept in the previous report
    localparam int INPUT_SLOTS = 6;   // slots carried on the input ports
    localparam int MOD_BITS    = 8;
    localparam int USAGE_W     = 8;

    localparam int SLOT_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
    localparam int IDX_W  = (SLOT_W > 3) ? SLOT_W : 3;

    localparam logic [USAGE_W-1:0] MOD_USAGE_BASE = 8'hE0;
    localparam logic [USAGE_W-1:0] USAGE_EMPTY    = 8'h00;

    typedef logic [USAGE_W-1:0] t_usage;
    typedef logic [IDX_W-1:0]   t_idx;
    typedef logic [SLOT_W-1:0]  t_slot;

endpackage

`default_nettype wire

[rtl/keyboard_report_make_break.sv]
// Boot keyboard report differ: top level, sequencer and shared key compare unit.
// Depends on kbd_mb_pkg.
//
// Usage:
//   Input channel (i_valid / o_stall): one boot keyboard report per
//   transaction, a modifier byte and six key usage slots. A transaction is
//   taken at a clock edge with i_valid high and o_stall low.
//   Output channel (o_valid / i_stall): one key event per transaction: usage,
//   make/break, the report's modifier byte and a last flag on the final
//   event of the report. A report identical to the previous one yields none.
//   Event order: changed modifier bits 0..7 (usage 0xE0 + bit), then makes
//   for new keys in slot order, then breaks for released keys in slot order.
// Timing:
//   The sequencer walks 8 modifier bits, then 2 x KEY_SLOTS slot checks, one
//   per cycle while no receiver stall freezes it, through one compare unit (a
//   candidate usage vs all slots of the other report), then a flush state.
//   o_stall is high from the accepting edge through the flush, so a new
//   report is taken only once the previous one has been flushed. An event
//   waits in a hold register until the next one is found or the flush comes,
//   which settles its last flag, and then moves to the output register.
//   Receiver stall freezes the walk when an event must move out and the
//   output register is still full.
// Reset:
//   Synchronous, active low. The previous report (modifiers and keys) is
//   cleared to zero and both channels go idle.
`default_nettype none

module keyboard_report_make_break (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // report in
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_modifier_bits,
    input  wire logic [7:0] i_key_slot0,
    input  wire logic [7:0] i_key_slot1,
    input  wire logic [7:0] i_key_slot2,
    input  wire logic [7:0] i_key_slot3,
    input  wire logic [7:0] i_key_slot4,
    input  wire logic [7:0] i_key_slot5,
    // key events out
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_usage_code,
    output logic            o_is_make,
    output logic [7:0]      o_current_modifiers,
    output logic            o_last_event
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,     // walk modifier bits
        S_MAKE,    // current slots vs previous report
        S_BREAK,   // previous slots vs current report
        S_FLUSH    // push the held event out as last
    } t_state;

    t_state                 r_state;
    kbd_mb_pkg::t_idx       r_idx;
    logic [7:0]             r_mods;
    logic [7:0]             r_prev_mods;
    kbd_mb_pkg::t_usage     r_cur  [kbd_mb_pkg::KEY_SLOTS];
    kbd_mb_pkg::t_usage     r_prev [kbd_mb_pkg::KEY_SLOTS];

    // one-event hold so the last flag can be decided
    logic                   r_hold_valid;
    kbd_mb_pkg::t_usage     r_hold_usage;
    logic                   r_hold_make;

    // output register
    logic                   r_out_valid;
    kbd_mb_pkg::t_usage     r_out_usage;
    logic                   r_out_make;
    logic [7:0]             r_out_mods;
    logic                   r_out_last;

    kbd_mb_pkg::t_usage     w_in   [kbd_mb_pkg::INPUT_SLOTS];
    kbd_mb_pkg::t_usage     w_load [kbd_mb_pkg::KEY_SLOTS];
    kbd_mb_pkg::t_slot      w_slot;
    logic [2:0]             w_bit;
    kbd_mb_pkg::t_usage     w_cand;
    logic                   w_hit;
    logic                   w_found;
    kbd_mb_pkg::t_usage     w_ev_usage;
    logic                   w_ev_make;
    logic                   w_scan;
    logic                   w_out_free;
    logic                   w_advance;
    logic                   w_swap;
    logic                   w_flush_push;
    logic                   w_flush_done;
    logic                   w_phase_end;

    assign w_in[0] = i_key_slot0;
    assign w_in[1] = i_key_slot1;
    assign w_in[2] = i_key_slot2;
    assign w_in[3] = i_key_slot3;
    assign w_in[4] = i_key_slot4;
    assign w_in[5] = i_key_slot5;

    // slots past the input ports read as empty
    for (genvar g = 0; g < kbd_mb_pkg::KEY_SLOTS; g++) begin : g_load
        if (g < kbd_mb_pkg::INPUT_SLOTS) begin : g_port
            assign w_load[g] = w_in[g];
        end else begin : g_empty
            assign w_load[g] = kbd_mb_pkg::USAGE_EMPTY;
        end
    end

    assign w_slot = r_idx[kbd_mb_pkg::SLOT_W-1:0];
    assign w_bit  = r_idx[2:0];

    // Shared compare unit: one candidate against every slot of the other report.
    always_comb begin
        w_cand = (r_state == S_BREAK) ? r_prev[w_slot] : r_cur[w_slot];
        w_hit  = 1'b0;
        for (int k = 0; k < kbd_mb_pkg::KEY_SLOTS; k++) begin
            if (r_state == S_BREAK) begin
                if (r_cur[k] == w_cand) w_hit = 1'b1;
            end else begin
                if (r_prev[k] == w_cand) w_hit = 1'b1;
            end
        end
    end

    always_comb begin
        w_found    = 1'b0;
        w_ev_usage = w_cand;
        w_ev_make  = 1'b0;
        unique case (r_state)
            S_MOD: begin
                w_found    = r_mods[w_bit] ^ r_prev_mods[w_bit];
                w_ev_usage = kbd_mb_pkg::MOD_USAGE_BASE + {5'b0, w_bit};
                w_ev_make  = r_mods[w_bit];
            end
            S_MAKE: begin
                w_found   = (w_cand != kbd_mb_pkg::USAGE_EMPTY) && !w_hit;
                w_ev_make = 1'b1;
            end
            S_BREAK: begin
                w_found   = (w_cand != kbd_mb_pkg::USAGE_EMPTY) && !w_hit;
                w_ev_make = 1'b0;
            end
            default: begin
                w_found = 1'b0;
            end
        endcase
    end

    assign w_scan       = (r_state == S_MOD) || (r_state == S_MAKE) || (r_state == S_BREAK);
    assign w_out_free   = !r_out_valid || !i_stall;
    // a found event with a full hold needs room in the output register
    assign w_advance    = w_scan && (!w_found || !r_hold_valid || w_out_free);
    assign w_swap       = w_scan && w_found && r_hold_valid && w_out_free;
    assign w_flush_push = (r_state == S_FLUSH) && r_hold_valid && w_out_free;
    assign w_flush_done = (r_state == S_FLUSH) && (!r_hold_valid || w_out_free);
    assign w_phase_end  = (r_state == S_MOD)
                        ? (r_idx == kbd_mb_pkg::t_idx'(kbd_mb_pkg::MOD_BITS - 1))
                        : (r_idx == kbd_mb_pkg::t_idx'(kbd_mb_pkg::KEY_SLOTS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_idx        <= '0;
            r_prev_mods  <= '0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            for (int k = 0; k < kbd_mb_pkg::KEY_SLOTS; k++) begin
                r_prev[k] <= kbd_mb_pkg::USAGE_EMPTY;
            end
        end else begin
            // output register
            if (w_swap || w_flush_push) begin
                r_out_valid <= 1'b1;
                r_out_usage <= r_hold_usage;
                r_out_make  <= r_hold_make;
                r_out_mods  <= r_mods;
                r_out_last  <= w_flush_push;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end

            // hold register
            if (w_advance && w_found) begin
                r_hold_valid <= 1'b1;
                r_hold_usage <= w_ev_usage;
                r_hold_make  <= w_ev_make;
            end else if (w_flush_push) begin
                r_hold_valid <= 1'b0;
            end

            // sequencer
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_mods  <= i_modifier_bits;
                        r_idx   <= '0;
                        r_state <= S_MOD;
                        for (int k = 0; k < kbd_mb_pkg::KEY_SLOTS; k++) begin
                            r_cur[k] <= w_load[k];
                        end
                    end
                end
                S_MOD, S_MAKE, S_BREAK: begin
                    if (w_advance) begin
                        if (w_phase_end) begin
                            r_idx <= '0;
                            unique case (r_state)
                                S_MOD:   r_state <= S_MAKE;
                                S_MAKE:  r_state <= S_BREAK;
                                default: r_state <= S_FLUSH;
                            endcase
                        end else begin
                            r_idx <= r_idx + kbd_mb_pkg::t_idx'(1);
                        end
                    end
                end
                S_FLUSH: begin
                    if (w_flush_done) begin
                        r_prev_mods <= r_mods;
                        for (int k = 0; k < kbd_mb_pkg::KEY_SLOTS; k++) begin
                            r_prev[k] <= r_cur[k];
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall             = (r_state != S_IDLE);
    assign o_valid             = r_out_valid;
    assign o_usage_code        = r_out_usage;
    assign o_is_make           = r_out_make;
    assign o_current_modifiers = r_out_mods;
    assign o_last_event        = r_out_last;

    // ---------------------------------------------------------------- checks

    // nothing may be left in the hold register between reports
    a_idle_hold_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_hold_valid)
        else $error("hold register not empty in idle");

    // a non-final event on the output always has a successor waiting
    a_not_last_has_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_last) |-> r_hold_valid)
        else $error("non-final event without a following event");

    // slot walk stays inside the slot range
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_MAKE) || (r_state == S_BREAK))
            |-> (r_idx <= kbd_mb_pkg::t_idx'(kbd_mb_pkg::KEY_SLOTS - 1)))
        else $error("slot index out of range");

    // the previous report only changes when a report finishes
    a_prev_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_FLUSH) |=> $stable(r_prev_mods))
        else $error("previous modifiers changed outside flush");

endmodule

`default_nettype wire

[sim/keyboard_report_make_break_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for keyboard_report_make_break: a scoreboard class predicts the
// key events of every accepted boot report and checks each event leaving the block.
// Depends on kbd_mb_pkg and the keyboard_report_make_break RTL.

module keyboard_report_make_break_tb;

    localparam int HOLD_OFF_CYCLES = 300;   // long receiver hold-off, fills the block
    localparam int WATCHDOG_LIMIT  = 5000;  // cycles with no transaction on either side
    localparam int ITEMS_PER_PHASE = 150;
    localparam int DRAIN_CYCLES    = 40;    // quiet tail after the last event
    localparam int MAX_REPORTS     = 10;    // mismatches printed in full

    // one boot report as it goes onto the input ports
    typedef struct packed {
        kbd_mb_pkg::t_usage                               mods;
        kbd_mb_pkg::t_usage [kbd_mb_pkg::INPUT_SLOTS-1:0] keys;
    } t_kbd_report;

    // one key event, in output port order
    typedef struct packed {
        kbd_mb_pkg::t_usage usage;
        logic               make;
        kbd_mb_pkg::t_usage mods;
        logic               last_flag;
    } t_key_event;

    // Predicts the event stream from the reports taken in, holds the events still due.
    class t_key_event_tracker;
        t_key_event                                     pending_events[$];
        kbd_mb_pkg::t_usage                             held_mods;
        kbd_mb_pkg::t_usage [kbd_mb_pkg::KEY_SLOTS-1:0] held_keys;
        int                                             err_count;

        function new();
            held_mods = kbd_mb_pkg::USAGE_EMPTY;
            held_keys = '0;
            err_count = 0;
        endfunction

        function bit has_usage(kbd_mb_pkg::t_usage [kbd_mb_pkg::KEY_SLOTS-1:0] slots,
                               kbd_mb_pkg::t_usage u);
            for (int i = 0; i < kbd_mb_pkg::KEY_SLOTS; i++)
                if (slots[i] == u) return 1'b1;
            return 1'b0;
        endfunction

        function void push_event(kbd_mb_pkg::t_usage u, logic mk, kbd_mb_pkg::t_usage m);
            t_key_event ev;
            ev = '{usage: u, make: mk, mods: m, last_flag: 1'b0};
            pending_events.push_back(ev);
        endfunction

        // modifier bits first, then new keys, then released keys
        function void take_report(kbd_mb_pkg::t_usage mods,
                                  kbd_mb_pkg::t_usage [kbd_mb_pkg::INPUT_SLOTS-1:0] keys);
            kbd_mb_pkg::t_usage [kbd_mb_pkg::KEY_SLOTS-1:0] cur;
            int                                             first;
            first = pending_events.size();
            for (int i = 0; i < kbd_mb_pkg::KEY_SLOTS; i++)
                cur[i] = (i < kbd_mb_pkg::INPUT_SLOTS) ? keys[i] : kbd_mb_pkg::USAGE_EMPTY;
            for (int b = 0; b < kbd_mb_pkg::MOD_BITS; b++)
                if (mods[b] != held_mods[b])
                    push_event(kbd_mb_pkg::MOD_USAGE_BASE + kbd_mb_pkg::t_usage'(b),
                               mods[b], mods);
            for (int i = 0; i < kbd_mb_pkg::KEY_SLOTS; i++)
                if (cur[i] != kbd_mb_pkg::USAGE_EMPTY && !has_usage(held_keys, cur[i]))
                    push_event(cur[i], 1'b1, mods);
            for (int i = 0; i < kbd_mb_pkg::KEY_SLOTS; i++)
                if (held_keys[i] != kbd_mb_pkg::USAGE_EMPTY && !has_usage(cur, held_keys[i]))
                    push_event(held_keys[i], 1'b0, mods);
            if (pending_events.size() > first)
                pending_events[pending_events.size()-1].last_flag = 1'b1;
            held_mods = mods;
            held_keys = cur;
        endfunction

        function void match_event(t_key_event got);
            t_key_event want;
            if (pending_events.size() == 0) begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("%0t: unexpected event usage %h make %b mods %h last %b",
                             $realtime, got.usage, got.make, got.mods, got.last_flag);
                return;
            end
            want = pending_events.pop_front();
            if (got.usage !== want.usage || got.make !== want.make ||
                got.mods !== want.mods || got.last_flag !== want.last_flag) begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("%0t: mismatch: expected usage %h make %b mods %h last %b, %s",
                             $realtime, want.usage, want.make, want.mods, want.last_flag,
                             $sformatf("got usage %h make %b mods %h last %b",
                                       got.usage, got.make, got.mods, got.last_flag));
            end
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n         = 1'b0;
    logic       i_valid         = 1'b0;
    logic       o_stall;
    logic [7:0] i_modifier_bits = '0;
    logic [7:0] i_key_slot0     = '0;
    logic [7:0] i_key_slot1     = '0;
    logic [7:0] i_key_slot2     = '0;
    logic [7:0] i_key_slot3     = '0;
    logic [7:0] i_key_slot4     = '0;
    logic [7:0] i_key_slot5     = '0;
    logic       o_valid;
    logic       i_stall         = 1'b0;
    logic [7:0] o_usage_code;
    logic       o_is_make;
    logic [7:0] o_current_modifiers;
    logic       o_last_event;

    t_key_event_tracker tracker = new();

    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    logic hold_off      = 1'b0;
    int   quiet_cycles  = 0;
    event burst_go;

    keyboard_report_make_break dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_modifier_bits     (i_modifier_bits),
        .i_key_slot0         (i_key_slot0),
        .i_key_slot1         (i_key_slot1),
        .i_key_slot2         (i_key_slot2),
        .i_key_slot3         (i_key_slot3),
        .i_key_slot4         (i_key_slot4),
        .i_key_slot5         (i_key_slot5),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_usage_code        (o_usage_code),
        .o_is_make           (o_is_make),
        .o_current_modifiers (o_current_modifiers),
        .o_last_event        (o_last_event)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // receiver: random stall, forced high during a hold-off burst
    always @(posedge i_clk) begin
        i_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
    end

    // hold-off burst, counted here so the sender keeps pushing meanwhile
    initial begin
        forever begin
            @(burst_go);
            hold_off <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            hold_off <= 1'b0;
        end
    end

    // both monitors sample the pre-edge values, so no race with the drivers
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall)
            tracker.take_report(i_modifier_bits, {i_key_slot5, i_key_slot4, i_key_slot3,
                                                  i_key_slot2, i_key_slot1, i_key_slot0});
        if (i_rst_n && o_valid && !i_stall)
            tracker.match_event({o_usage_code, o_is_make, o_current_modifiers, o_last_event});
    end

    // watchdog on stretches with no transaction on either channel
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic t_kbd_report mk_report(
        kbd_mb_pkg::t_usage m,  kbd_mb_pkg::t_usage k0, kbd_mb_pkg::t_usage k1,
        kbd_mb_pkg::t_usage k2, kbd_mb_pkg::t_usage k3, kbd_mb_pkg::t_usage k4,
        kbd_mb_pkg::t_usage k5);
        t_kbd_report r;
        r.mods = m;
        r.keys = {k5, k4, k3, k2, k1, k0};
        return r;
    endfunction

    // Next report of a random run: mostly typing that grows out of the previous report,
    // with unchanged resends, odd slot contents and plain noise mixed in.
    function automatic t_kbd_report evolve_report(t_kbd_report prev);
        t_kbd_report r;
        int          kind;
        int          s;
        int          free_slot;
        r    = prev;
        kind = $urandom_range(99);
        if (kind < 8) begin
            r.mods = kbd_mb_pkg::t_usage'($urandom);
            for (int i = 0; i < kbd_mb_pkg::INPUT_SLOTS; i++)
                r.keys[i] = kbd_mb_pkg::t_usage'($urandom);
        end else if (kind < 14) begin
            r = prev;   // resend, no events due
        end else if (kind < 22) begin
            repeat ($urandom_range(1, 3)) begin
                s = $urandom_range(kbd_mb_pkg::INPUT_SLOTS-1);
                case ($urandom_range(3))
                    0: r.keys[s] = kbd_mb_pkg::t_usage'($urandom);
                    1: r.keys[s] = kbd_mb_pkg::MOD_USAGE_BASE
                                 + kbd_mb_pkg::t_usage'($urandom_range(7));
                    2: r.keys[s] = r.keys[$urandom_range(kbd_mb_pkg::INPUT_SLOTS-1)];
                    default: r.mods = kbd_mb_pkg::t_usage'($urandom);
                endcase
            end
        end else begin
            repeat ($urandom_range(1, 3)) begin
                case ($urandom_range(3))
                    0, 1: begin
                        // press: first free slot, else overwrite one
                        free_slot = kbd_mb_pkg::INPUT_SLOTS;
                        for (int i = kbd_mb_pkg::INPUT_SLOTS-1; i >= 0; i--)
                            if (r.keys[i] == kbd_mb_pkg::USAGE_EMPTY) free_slot = i;
                        if (free_slot == kbd_mb_pkg::INPUT_SLOTS)
                            free_slot = $urandom_range(kbd_mb_pkg::INPUT_SLOTS-1);
                        r.keys[free_slot] = 8'h04 + kbd_mb_pkg::t_usage'($urandom_range(11));
                    end
                    2: r.keys[$urandom_range(kbd_mb_pkg::INPUT_SLOTS-1)] =
                           kbd_mb_pkg::USAGE_EMPTY;
                    default: begin
                        s = $urandom_range(kbd_mb_pkg::MOD_BITS-1);
                        r.mods[s] = ~r.mods[s];
                    end
                endcase
            end
        end
        return r;
    endfunction

    // offer one report, return at the edge that takes it; valid stays high afterward
    task automatic send_report(input t_kbd_report r);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_modifier_bits <= r.mods;
        i_key_slot0     <= r.keys[0];
        i_key_slot1     <= r.keys[1];
        i_key_slot2     <= r.keys[2];
        i_key_slot3     <= r.keys[3];
        i_key_slot4     <= r.keys[4];
        i_key_slot5     <= r.keys[5];
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // sender pause until every predicted event has left the block
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending_events.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_idling(input int sender_pct, input int receiver_pct);
        send_idle_pct = sender_pct;
        recv_idle_pct <= receiver_pct;
    endtask

    initial begin
        t_kbd_report rpt;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_idling(9, 82);

        // directed: reset state, extremes, duplicates, modifier usages in slots
        send_report(mk_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00)); // no change
        send_report(mk_report(8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00)); // all mods make
        send_report(mk_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00)); // all break
        send_report(mk_report(8'hFF, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09));
        send_report(mk_report(8'h00, 8'hFF, 8'hFE, 8'hFD, 8'hFC, 8'hFB, 8'hFA)); // 20 events
        send_report(mk_report(8'h00, 8'hFF, 8'hFE, 8'hFD, 8'hFC, 8'hFB, 8'hFA)); // no change
        send_report(mk_report(8'h00, 8'hFA, 8'hFB, 8'hFC, 8'hFD, 8'hFE, 8'hFF)); // same set
        send_report(mk_report(8'h00, 8'h10, 8'h10, 8'h10, 8'h10, 8'h10, 8'h10)); // dup makes
        send_report(mk_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00)); // dup breaks
        send_report(mk_report(8'h01, 8'hE0, 8'hE1, 8'hE2, 8'hE3, 8'hE4, 8'hE5));
        send_report(mk_report(8'h00, 8'hE0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_report(mk_report(8'hAA, 8'h00, 8'hE7, 8'h00, 8'hE6, 8'h00, 8'h00));
        send_report(mk_report(8'h55, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80));
        send_report(mk_report(8'h80, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01)); // rollover
        send_report(mk_report(8'h80, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01));
        send_report(mk_report(8'h7F, 8'h04, 8'h00, 8'h04, 8'h00, 8'h05, 8'h00));
        send_report(mk_report(8'h7F, 8'h00, 8'h05, 8'h00, 8'h06, 8'h00, 8'h04));
        rpt = mk_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_report(rpt);
        wait_drained();

        // random phases: busy receiver, busy sender, then full rate with a hold-off burst
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: set_idling(9, 82);
                1: set_idling(82, 9);
                default: set_idling(0, 0);
            endcase
            if (phase == 2) -> burst_go;
            repeat (ITEMS_PER_PHASE) begin
                rpt = evolve_report(rpt);
                send_report(rpt);
            end
            wait_drained();
        end

        // quiet tail: any late event shows up as unexpected
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (tracker.err_count == 0 && tracker.pending_events.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[sim.f]
rtl/kbd_mb_pkg.sv
rtl/keyboard_report_make_break.sv
sim/keyboard_report_make_break_tb.sv
